@@ design/pbp_pkg.sv @@
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types, constants and the saturating weight step for the perceptron
// branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

   // Weight and threshold widths
   localparam int WEIGHT_W   = 8;
   localparam int THRESH_W   = 11;
   localparam int GROUP_SIZE = 4;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd37;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 8'h7F;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MIN   = 8'h80;

   // Load enables for the two adder-tree stages
   typedef struct packed {
      logic grp_load;
      logic sum_load;
   } dot_ctrl_type;

   // One training step on a weight, saturating at -128 and 127
   function automatic logic [WEIGHT_W-1:0] sat_step(input logic [WEIGHT_W-1:0] w,
                                                    input logic up);
      logic [WEIGHT_W-1:0] r;
      if (up) begin
         r = (w == WEIGHT_MAX) ? w : w + WEIGHT_W'(1);
      end else begin
         r = (w == WEIGHT_MIN) ? w : w - WEIGHT_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/pbp_dot.sv @@
// ----------------------------------------------------------------------------
// pbp_dot
// Two-stage registered adder tree: bias plus signed weights, each taken as
// +w or -w by its history bit. Stage one sums groups, stage two the groups.
// ----------------------------------------------------------------------------
`default_nettype none

module pbp_dot #(
   parameter int HISTORY_LEN = 12,
   parameter int SUM_W       = 13
) (
   input  wire                                            clock,
   input  pbp_pkg::dot_ctrl_type                          ctrl,
   input  wire [(HISTORY_LEN+1)*pbp_pkg::WEIGHT_W-1:0]    row_data,
   input  wire [HISTORY_LEN-1:0]                          hist,
   output logic signed [SUM_W-1:0]                        sum_total
);

   localparam int WW   = pbp_pkg::WEIGHT_W;
   localparam int GS   = pbp_pkg::GROUP_SIZE;
   localparam int NT   = HISTORY_LEN + 1;
   localparam int NGRP = (NT + GS - 1) / GS;
   localparam int NPAD = NGRP * GS;

   logic signed [SUM_W-1:0] term   [NPAD];
   logic signed [SUM_W-1:0] grp_in [NGRP];
   logic signed [SUM_W-1:0] grp_ff [NGRP];
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum_ff;

   // Signed terms; weight i pairs with history bit HISTORY_LEN-i
   always_comb begin
      for (int t = 0; t < NPAD; t++) begin
         term[t] = '0;
      end
      term[0] = SUM_W'($signed(row_data[0 +: WW]));
      for (int t = 1; t < NT; t++) begin
         if (hist[HISTORY_LEN-t]) begin
            term[t] = SUM_W'($signed(row_data[t*WW +: WW]));
         end else begin
            term[t] = -SUM_W'($signed(row_data[t*WW +: WW]));
         end
      end
   end

   // Stage one: group partial sums
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GS; k++) begin
            grp_in[g] = grp_in[g] + term[g*GS+k];
         end
      end
   end

   // Stage two: total of the groups
   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         sum_in = sum_in + grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.grp_load) begin
         grp_ff <= grp_in;
      end
      if (ctrl.sum_load) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_total = sum_ff;

endmodule

`default_nettype wire

@@ design/perceptron_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// perceptron_branch_predictor
// Perceptron predictor: one weight row per branch is read, summed, trained
// and written back; the resolved outcome shifts into the global history.
// ----------------------------------------------------------------------------
// Each req beat is a resolved branch; each rsp beat is the prediction made for
// it before training. The row index is the low INDEX_BITS of the PC xor the
// global history. An item goes through the row read from the weight memory,
// the first adder-tree stage and the second adder-tree stage; the write-back
// and the result happen as the update state ends, on the edge that can also
// accept the next item, so a new item is taken only as the last one finishes,
// and a stalled rsp holds both. A row written back is forwarded when the next
// item hits the same row. After reset a clearing pass zeroes all 2^INDEX_BITS
// rows of the weight memory, one row per cycle; req is stalled meanwhile. The
// threshold register may be written at any time through csr but should only
// change while no branch is in flight.
`default_nettype none

module perceptron_branch_predictor #(
   parameter int HISTORY_LEN = 12,
   parameter int INDEX_BITS  = 8
) (
   input  wire                           clock,
   input  wire                           reset,
   // Branch input channel
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire [31:0]                    req_branch_pc,
   input  wire                           req_taken,
   // Prediction output channel
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic                          rsp_predict_taken,
   // Threshold register write
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [pbp_pkg::THRESH_W-1:0]   csr_train_threshold
);

   localparam int WW    = pbp_pkg::WEIGHT_W;
   localparam int TW    = pbp_pkg::THRESH_W;
   localparam int ROWS  = 1 << INDEX_BITS;
   localparam int ROW_W = (HISTORY_LEN + 1) * WW;
   localparam int SUM_W = $clog2(HISTORY_LEN + 1) + WW + 1;
   localparam int CMP_W = (SUM_W > TW) ? SUM_W + 1 : TW + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GRP,
      ST_TOT,
      ST_UPD
   } state_type;

   state_type               state_ff, state_in;
   logic [INDEX_BITS-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [HISTORY_LEN-1:0]  ghist_ff, ghist_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_pred_ff;
   logic [TW-1:0]           thr_ff;

   // Item context
   logic [INDEX_BITS-1:0]   idx_ff;
   logic [HISTORY_LEN-1:0]  hist_ff;
   logic                    taken_ff;
   logic [ROW_W-1:0]        row_ff;

   // Weight memory and forwarding
   logic [ROW_W-1:0]        weight_mem [ROWS];
   logic [ROW_W-1:0]        mem_rd_ff;
   logic                    fwd_sel_ff;
   logic [ROW_W-1:0]        fwd_row_ff;
   logic                    mem_we;
   logic [INDEX_BITS-1:0]   mem_wa;
   logic [ROW_W-1:0]        mem_wd;

   logic                    req_accept;
   logic                    out_free;
   logic                    upd_fire;
   logic [31:0]             pc_x_hist;
   logic [INDEX_BITS-1:0]   rd_idx;
   logic [ROW_W-1:0]        row_src;
   logic [ROW_W-1:0]        new_row;
   logic signed [SUM_W-1:0] sum_total;
   logic signed [CMP_W-1:0] sum_x;
   logic signed [CMP_W-1:0] mag;
   logic signed [CMP_W-1:0] thr_x;
   logic                    pred;
   logic                    train;
   pbp_pkg::dot_ctrl_type   dot_ctrl;

   // Handshakes
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign upd_fire   = (state_ff == ST_UPD) && out_free;
   assign req_stall  = !((state_ff == ST_IDLE) || upd_fire);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_predict_taken = rsp_pred_ff;

   // Row index from PC xor history
   assign pc_x_hist = req_branch_pc ^ 32'(ghist_ff);
   assign rd_idx    = pc_x_hist[INDEX_BITS-1:0];

   // Row data: forwarded write-back or memory read
   assign row_src = fwd_sel_ff ? fwd_row_ff : mem_rd_ff;

   // Dot product
   assign dot_ctrl.grp_load = (state_ff == ST_GRP);
   assign dot_ctrl.sum_load = (state_ff == ST_TOT);

   pbp_dot #(
      .HISTORY_LEN (HISTORY_LEN),
      .SUM_W       (SUM_W)
   ) u_dot (
      .clock     (clock),
      .ctrl      (dot_ctrl),
      .row_data  (row_src),
      .hist      (hist_ff),
      .sum_total (sum_total)
   );

   // Prediction and training decision
   always_comb begin
      pred  = !sum_total[SUM_W-1];
      sum_x = CMP_W'(sum_total);
      mag   = pred ? sum_x : -sum_x;
      thr_x = CMP_W'(thr_ff);
      train = (pred != taken_ff) || (mag < thr_x);
   end

   // Trained row
   always_comb begin
      new_row = row_ff;
      if (train) begin
         new_row[0 +: WW] = pbp_pkg::sat_step(row_ff[0 +: WW], taken_ff);
         for (int i = 1; i <= HISTORY_LEN; i++) begin
            new_row[i*WW +: WW] = pbp_pkg::sat_step(row_ff[i*WW +: WW],
                                                    taken_ff == hist_ff[HISTORY_LEN-i]);
         end
      end
   end

   // Memory write port: clearing pass or write-back
   always_comb begin
      mem_we = (state_ff == ST_CLEAR) || upd_fire;
      mem_wa = (state_ff == ST_CLEAR) ? clr_cnt_ff : idx_ff;
      mem_wd = (state_ff == ST_CLEAR) ? '0 : new_row;
   end

   // Weight memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[mem_wa] <= mem_wd;
      end
      if (req_accept) begin
         mem_rd_ff <= weight_mem[rd_idx];
      end
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      ghist_in     = ghist_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + INDEX_BITS'(1);
            if (clr_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_GRP;
            end
         end
         ST_GRP: begin
            state_in = ST_TOT;
         end
         ST_TOT: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = req_accept ? ST_GRP : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (req_accept) begin
         ghist_in = HISTORY_LEN'({ghist_ff, req_taken});
      end
   end

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         ghist_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fwd_sel_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         ghist_ff     <= ghist_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_fire) begin
            rsp_pred_ff <= pred;
         end
         if (req_accept) begin
            fwd_sel_ff <= upd_fire && (rd_idx == idx_ff);
            fwd_row_ff <= new_row;
         end
      end
   end

   // Item context capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_ff   <= rd_idx;
         hist_ff  <= ghist_ff;
         taken_ff <= req_taken;
      end
      if (state_ff == ST_GRP) begin
         row_ff <= row_src;
      end
   end

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= pbp_pkg::THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_train_threshold;
      end
   end

endmodule

`default_nettype wire
